### design/visual_servo_aim_and_approach_macros.svh
// Assertion macros for the visual servo block.
// Used by the top level only; needs clk and rst_n in scope.
`ifndef VISUAL_SERVO_AIM_AND_APPROACH_MACROS_SVH
`define VISUAL_SERVO_AIM_AND_APPROACH_MACROS_SVH
// same-cycle implication
`define VSAA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define VSAA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### design/vsaa_pkg.sv
// Package for the visual servo block: types, constants, trig table function.
// No dependencies.
`timescale 1ns / 1ps
package vsaa_pkg;
  localparam int TARGET_LIMIT_DEF = 70000;
  localparam int TRIG_BITS_DEF    = 8;
  localparam int UNIT_W           = 48;
  localparam int CNT_W            = 6;
  localparam int EDGE_ZONE        = 40000;
  localparam int WZ_DIV           = 70000;
  localparam int WZ_FULL          = 500;
  localparam int SPEED_FULL       = 500;
  localparam int PHASE_NUM        = 20480000;
  localparam int PHASE_DEN        = 764047;
  localparam int BASE_TERM        = 60 * 240 * 256;
  localparam longint SPEED_DEN    = 64'd16384 * 240 * 256;

  typedef enum logic [2:0] {
    CFG_AIM_GAIN, CFG_APPROACH_GAIN, CFG_X_DEADBAND,
    CFG_GRAB_Y, CFG_Y_DEADBAND, CFG_CHASSIS_SCALE
  } cfg_reg_t;

  typedef enum logic {UOP_MUL, UOP_DIV} unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLAMP, S_GAIN, S_WZ_MUL, S_WZ_DIV, S_PH_MUL, S_PH_DIV, S_TRIG,
    S_T1, S_T2, S_VX_MUL, S_VX_DIV, S_VY_MUL, S_VY_DIV, S_DONE
  } state_t;

  function automatic logic [14:0] quarter_sin(input longint u);
    longint x2;
    longint acc;
    longint r;
    x2  = (u * u) >>> 16;
    acc = 43069;
    acc = -1256749 + ((acc * x2) >>> 16);
    acc = 21392326 + ((acc * x2) >>> 16);
    acc = -173399667 + ((acc * x2) >>> 16);
    acc = 421657428 + ((acc * x2) >>> 16);
    r   = (acc * u) >>> 16;
    if (r <= 0) begin
      return 15'd0;
    end
    r = (r + 8192) >>> 14;
    if (r > 16384) begin
      r = 16384;
    end
    return 15'(r);
  endfunction
endpackage

### design/vsaa_serial_unit.sv
// Shared bit-serial multiplier and restoring divider, one bit per cycle.
// Depends on vsaa_pkg.
`timescale 1ns / 1ps
module vsaa_serial_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  vsaa_pkg::unit_req_t        req,
  input  logic [vsaa_pkg::UNIT_W-1:0] opa,
  input  logic [vsaa_pkg::UNIT_W-1:0] opb,
  output vsaa_pkg::unit_stat_t       stat,
  output logic [vsaa_pkg::UNIT_W-1:0] result
);
  localparam int W = vsaa_pkg::UNIT_W;
  logic [W-1:0] a_r, a_nxt, sh_r, sh_nxt, acc_r, acc_nxt;
  logic [vsaa_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  vsaa_pkg::unit_op_t op_r, op_nxt;
  logic [W-1:0] rem_sh;
  logic [W:0]   diff;

  assign rem_sh = {acc_r[W-2:0], sh_r[W-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, a_r};

  always_comb begin
    a_nxt = a_r; sh_nxt = sh_r; acc_nxt = acc_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0; op_nxt = op_r;
    if (req.start && !busy_r) begin
      a_nxt = opa; sh_nxt = opb; acc_nxt = '0; cnt_nxt = '0;
      busy_nxt = 1'b1; op_nxt = req.op;
    end else if (busy_r) begin
      case (op_r)
        vsaa_pkg::UOP_MUL: begin
          acc_nxt = {acc_r[W-2:0], 1'b0} + (sh_r[W-1] ? a_r : '0);
          sh_nxt  = {sh_r[W-2:0], 1'b0};
        end
        vsaa_pkg::UOP_DIV: begin
          acc_nxt = diff[W] ? rem_sh : diff[W-1:0];
          sh_nxt  = {sh_r[W-2:0], ~diff[W]};
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == vsaa_pkg::CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= vsaa_pkg::UOP_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
    a_r   <= a_nxt;
    sh_r  <= sh_nxt;
    acc_r <= acc_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign result    = (op_r == vsaa_pkg::UOP_MUL) ? acc_r : sh_r;
endmodule

### design/vsaa_trig_rom.sv
// Q14 sine lookup by quarter-wave symmetry over a constant quarter table.
// Depends on vsaa_pkg.
`timescale 1ns / 1ps
module vsaa_trig_rom #(
  parameter int TABLE_BITS = vsaa_pkg::TRIG_BITS_DEF
) (
  input  logic [TABLE_BITS-1:0] addr,
  output logic [14:0]           mag,
  output logic                  neg
);
  localparam int QN = 1 << (TABLE_BITS - 2);
  logic [14:0] tab [QN+1];
  logic [TABLE_BITS-2:0] r, k;

  for (genvar i = 0; i <= QN; i++) begin : g_tab
    assign tab[i] = vsaa_pkg::quarter_sin(longint'(i) <<< (18 - TABLE_BITS));
  end

  assign r   = {1'b0, addr[TABLE_BITS-3:0]};
  assign k   = addr[TABLE_BITS-2] ? ((TABLE_BITS-1)'(QN) - r) : r;
  assign mag = tab[k];
  assign neg = addr[TABLE_BITS-1];
endmodule

### design/visual_servo_aim_and_approach.sv
// Visual servo: aims a gimbal at the ball, then drives the chassis up to it.
// Each tick runs its operations one after another on the shared serial
// multiply/divide unit (3 operations in aim, 9 in approach, one in a grab tick
// and none in a switch into approach).
// One tick is in flight at a time; the next beat is taken as soon as the result
// sits in the output register.
// Depends on vsaa_pkg, vsaa_serial_unit, vsaa_trig_rom and the macros header.
`timescale 1ns / 1ps
`include "visual_servo_aim_and_approach_macros.svh"
module visual_servo_aim_and_approach #(
  parameter int TARGET_LIMIT    = vsaa_pkg::TARGET_LIMIT_DEF,
  parameter int TRIG_TABLE_BITS = vsaa_pkg::TRIG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // ball_x[9:0], ball_y[18:10]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // gimbal_target[17:0], chassis_vx[32:18],
                                  // chassis_vy[47:33], chassis_wz[57:48],
                                  // grab_pulse[58], mode_now[59]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  localparam int W = vsaa_pkg::UNIT_W;
  localparam int B = TRIG_TABLE_BITS;
  localparam logic signed [17:0] LIM = 18'(TARGET_LIMIT);
  localparam logic signed [17:0] EDGE = 18'(vsaa_pkg::EDGE_ZONE);

  vsaa_pkg::state_t state_r, state_nxt;
  logic signed [7:0]  aim_gain_r, app_gain_r;
  logic [8:0]         xdb_r;
  logic signed [8:0]  grab_y_r;
  logic [7:0]         ydb_r;
  logic [11:0]        scale_r;
  logic signed [9:0]  x_r, x_nxt;
  logic signed [8:0]  y_r, y_nxt;
  logic signed [17:0] tgt_r, tgt_nxt;
  logic               mode_r, mode_nxt, grab_r, grab_nxt, launched_r, launched_nxt;
  logic signed [14:0] vx_r, vx_nxt, vy_r, vy_nxt;
  logic signed [9:0]  wz_r, wz_nxt;
  logic [23:0]        phase_r, phase_nxt;
  logic [14:0]        smag_r, smag_nxt, cmag_r, cmag_nxt;
  logic               sneg_r, sneg_nxt, cneg_r, cneg_nxt;
  logic [31:0]        tmag_r, tmag_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [63:0]        out_data_r, out_data_nxt;

  vsaa_pkg::unit_req_t  req;
  vsaa_pkg::unit_stat_t stat;
  logic [W-1:0] opa, opb, res;

  logic signed [17:0] tgt_cl;
  logic [17:0]        tgt_mag;
  logic signed [10:0] x_w, xdb_w, y_lo, y_hi, y_w;
  logic               off_centre, y_out;
  logic signed [9:0]  dy;
  logic [9:0]         dy_mag;
  logic signed [7:0]  gain;
  logic [7:0]         gain_mag;
  logic [9:0]         x_mag;
  logic signed [19:0] tsum;
  logic signed [17:0] tsum_sat;
  logic [23:0]        phase_rnd;
  logic [B-1:0]       sin_a, cos_a;
  logic [14:0]        s_mag, c_mag;
  logic               s_neg, c_neg;
  logic [9:0]         wz_q;
  logic               op_state, accept;

  function automatic logic signed [14:0] speed_sat(input logic [W-1:0] q, input logic neg);
    logic signed [14:0] v;
    if (neg) begin
      v = (q > W'(16384)) ? -15'sd16384 : -$signed(q[14:0]);
    end else begin
      v = (q > W'(16383)) ? 15'sd16383 : $signed(q[14:0]);
    end
    return v;
  endfunction

  vsaa_serial_unit u_unit (
    .clk(clk), .rst_n(rst_n), .req(req), .opa(opa), .opb(opb), .stat(stat), .result(res)
  );

  vsaa_trig_rom #(.TABLE_BITS(B)) u_sin (.addr(sin_a), .mag(s_mag), .neg(s_neg));
  vsaa_trig_rom #(.TABLE_BITS(B)) u_cos (.addr(cos_a), .mag(c_mag), .neg(c_neg));

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == vsaa_pkg::S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign tgt_cl  = (tgt_r > LIM) ? LIM : ((tgt_r < -LIM) ? -LIM : tgt_r);
  assign tgt_mag = tgt_r[17] ? 18'(-tgt_r) : 18'(tgt_r);
  assign x_w     = 11'(x_r);
  assign xdb_w   = $signed({2'b0, xdb_r});
  assign off_centre = (x_w > xdb_w) || (x_w < -xdb_w) || (tgt_cl >= EDGE) || (tgt_cl <= -EDGE);
  assign y_w     = 11'(y_r);
  assign y_hi    = 11'(grab_y_r) + $signed({3'b0, ydb_r});
  assign y_lo    = 11'(grab_y_r) - $signed({3'b0, ydb_r});
  assign y_out   = (y_w > y_hi) || (y_w < y_lo);
  assign dy      = 10'(y_r) - 10'(grab_y_r);
  assign dy_mag  = dy[9] ? 10'(-dy) : 10'(dy);
  assign gain    = mode_r ? app_gain_r : aim_gain_r;
  assign gain_mag = gain[7] ? 8'(-gain) : 8'(gain);
  assign x_mag   = x_r[9] ? 10'(-x_r) : 10'(x_r);
  assign tsum    = 20'(tgt_r) + ((gain[7] ^ x_r[9]) ? -$signed({2'b0, res[17:0]})
                                                     : $signed({2'b0, res[17:0]}));
  assign tsum_sat = (tsum > 20'sd131071) ? 18'sd131071
                  : ((tsum < -20'sd131072) ? -18'sd131072 : tsum[17:0]);
  assign phase_rnd = phase_r + 24'(1 << (23 - B));
  assign sin_a   = phase_rnd[23:24-B];
  assign cos_a   = sin_a + B'(1 << (B - 2));
  assign wz_q    = (res > W'(vsaa_pkg::WZ_FULL)) ? 10'(vsaa_pkg::WZ_FULL) : res[9:0];

  assign op_state = (state_r != vsaa_pkg::S_IDLE) && (state_r != vsaa_pkg::S_CLAMP) &&
                    (state_r != vsaa_pkg::S_TRIG) && (state_r != vsaa_pkg::S_DONE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vsaa_pkg::S_IDLE:   if (accept) state_nxt = vsaa_pkg::S_CLAMP;
      vsaa_pkg::S_CLAMP:  state_nxt = (!mode_r && !off_centre) ? vsaa_pkg::S_DONE
                                                               : vsaa_pkg::S_GAIN;
      vsaa_pkg::S_GAIN:   if (stat.done) begin
        if (!mode_r) state_nxt = vsaa_pkg::S_WZ_MUL;
        else state_nxt = y_out ? vsaa_pkg::S_PH_MUL : vsaa_pkg::S_DONE;
      end
      vsaa_pkg::S_WZ_MUL: if (stat.done) state_nxt = vsaa_pkg::S_WZ_DIV;
      vsaa_pkg::S_WZ_DIV: if (stat.done) state_nxt = vsaa_pkg::S_DONE;
      vsaa_pkg::S_PH_MUL: if (stat.done) state_nxt = vsaa_pkg::S_PH_DIV;
      vsaa_pkg::S_PH_DIV: if (stat.done) state_nxt = vsaa_pkg::S_TRIG;
      vsaa_pkg::S_TRIG:   state_nxt = vsaa_pkg::S_T1;
      vsaa_pkg::S_T1:     if (stat.done) state_nxt = vsaa_pkg::S_T2;
      vsaa_pkg::S_T2:     if (stat.done) state_nxt = vsaa_pkg::S_VX_MUL;
      vsaa_pkg::S_VX_MUL: if (stat.done) state_nxt = vsaa_pkg::S_VX_DIV;
      vsaa_pkg::S_VX_DIV: if (stat.done) state_nxt = vsaa_pkg::S_VY_MUL;
      vsaa_pkg::S_VY_MUL: if (stat.done) state_nxt = vsaa_pkg::S_VY_DIV;
      vsaa_pkg::S_VY_DIV: if (stat.done) state_nxt = vsaa_pkg::S_DONE;
      vsaa_pkg::S_DONE:   if (!out_valid_r || out_tready) state_nxt = vsaa_pkg::S_IDLE;
      default:            state_nxt = vsaa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; tgt_nxt = tgt_r; mode_nxt = mode_r; grab_nxt = grab_r;
    vx_nxt = vx_r; vy_nxt = vy_r; wz_nxt = wz_r; phase_nxt = phase_r;
    smag_nxt = smag_r; cmag_nxt = cmag_r; sneg_nxt = sneg_r; cneg_nxt = cneg_r;
    tmag_nxt = tmag_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    req.start = op_state && !launched_r && !stat.busy;
    req.op    = vsaa_pkg::UOP_MUL;
    opa = '0; opb = '0;
    launched_nxt = launched_r;
    if (req.start) launched_nxt = 1'b1;
    if (stat.done) launched_nxt = 1'b0;
    case (state_r)
      vsaa_pkg::S_IDLE: begin
        if (accept) begin
          x_nxt = $signed(in_tdata[9:0]);
          y_nxt = $signed(in_tdata[18:10]);
        end
      end
      vsaa_pkg::S_CLAMP: begin
        tgt_nxt  = tgt_cl;
        grab_nxt = 1'b0;
        if (!mode_r && !off_centre) mode_nxt = 1'b1;
      end
      vsaa_pkg::S_GAIN: begin
        opa = W'(gain_mag); opb = W'(x_mag);
        if (stat.done) begin
          tgt_nxt = tsum_sat;
          if (mode_r && !y_out) begin
            grab_nxt = 1'b1;
            mode_nxt = 1'b0;
          end
        end
      end
      vsaa_pkg::S_WZ_MUL: begin
        opa = W'(tgt_mag); opb = W'(vsaa_pkg::WZ_FULL);
      end
      vsaa_pkg::S_WZ_DIV: begin
        req.op = vsaa_pkg::UOP_DIV;
        opa = W'(vsaa_pkg::WZ_DIV); opb = res + W'(vsaa_pkg::WZ_DIV / 2);
        if (stat.done) wz_nxt = tgt_r[17] ? $signed(wz_q) : -$signed(wz_q);
      end
      vsaa_pkg::S_PH_MUL: begin
        opa = W'(tgt_mag); opb = W'(vsaa_pkg::PHASE_NUM);
      end
      vsaa_pkg::S_PH_DIV: begin
        req.op = vsaa_pkg::UOP_DIV;
        opa = W'(vsaa_pkg::PHASE_DEN); opb = res + W'(vsaa_pkg::PHASE_DEN / 2);
        if (stat.done) begin
          phase_nxt = (!tgt_r[17] && (tgt_r != '0)) ? 24'(-res[23:0]) : res[23:0];
        end
      end
      vsaa_pkg::S_TRIG: begin
        smag_nxt = s_mag; sneg_nxt = s_neg;
        cmag_nxt = c_mag; cneg_nxt = c_neg;
      end
      vsaa_pkg::S_T1: begin
        opa = W'(dy_mag); opb = W'(vsaa_pkg::SPEED_FULL);
      end
      vsaa_pkg::S_T2: begin
        opa = res; opb = W'(scale_r);
        if (stat.done) tmag_nxt = res[31:0] + 32'(vsaa_pkg::BASE_TERM);
      end
      vsaa_pkg::S_VX_MUL: begin
        opa = W'(tmag_r); opb = W'(smag_r);
      end
      vsaa_pkg::S_VX_DIV: begin
        req.op = vsaa_pkg::UOP_DIV;
        opa = W'(vsaa_pkg::SPEED_DEN); opb = res + W'(vsaa_pkg::SPEED_DEN / 2);
        if (stat.done) vx_nxt = speed_sat(res, sneg_r ^ dy[9]);
      end
      vsaa_pkg::S_VY_MUL: begin
        opa = W'(tmag_r); opb = W'(cmag_r);
      end
      vsaa_pkg::S_VY_DIV: begin
        req.op = vsaa_pkg::UOP_DIV;
        opa = W'(vsaa_pkg::SPEED_DEN); opb = res + W'(vsaa_pkg::SPEED_DEN / 2);
        if (stat.done) begin
          vy_nxt = speed_sat(res, cneg_r ^ dy[9]);
          wz_nxt = '0;
        end
      end
      vsaa_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'b0, mode_r, grab_r, wz_r, vy_r, vx_r, tgt_r};
        end
      end
      default: begin
        out_data_nxt = out_data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vsaa_pkg::S_IDLE;
      aim_gain_r  <= -8'sd6;
      app_gain_r  <= -8'sd6;
      xdb_r       <= 9'd5;
      grab_y_r    <= -9'sd80;
      ydb_r       <= 8'd10;
      scale_r     <= 12'd256;
      tgt_r       <= '0;
      mode_r      <= 1'b0;
      grab_r      <= 1'b0;
      vx_r        <= '0;
      vy_r        <= '0;
      wz_r        <= '0;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tgt_r       <= tgt_nxt;
      mode_r      <= mode_nxt;
      grab_r      <= grab_nxt;
      vx_r        <= vx_nxt;
      vy_r        <= vy_nxt;
      wz_r        <= wz_nxt;
      launched_r  <= launched_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (vsaa_pkg::cfg_reg_t'(cfg_index))
          vsaa_pkg::CFG_AIM_GAIN:      aim_gain_r <= $signed(cfg_data[7:0]);
          vsaa_pkg::CFG_APPROACH_GAIN: app_gain_r <= $signed(cfg_data[7:0]);
          vsaa_pkg::CFG_X_DEADBAND:    xdb_r      <= cfg_data[8:0];
          vsaa_pkg::CFG_GRAB_Y:        grab_y_r   <= $signed(cfg_data[8:0]);
          vsaa_pkg::CFG_Y_DEADBAND:    ydb_r      <= cfg_data[7:0];
          vsaa_pkg::CFG_CHASSIS_SCALE: scale_r    <= cfg_data;
          default:                     scale_r    <= scale_r;
        endcase
      end
    end
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    phase_r    <= phase_nxt;
    smag_r     <= smag_nxt;
    cmag_r     <= cmag_nxt;
    sneg_r     <= sneg_nxt;
    cneg_r     <= cneg_nxt;
    tmag_r     <= tmag_nxt;
    out_data_r <= out_data_nxt;
  end

  `VSAA_ASSERT_IMP(a_grab_aim, out_valid_r && out_data_r[58], !out_data_r[59], "grab not in aim")
  `VSAA_ASSERT_NXT(a_busy_after_take, accept, !in_tready, "beat taken while busy")
  `VSAA_ASSERT_IMP(a_wz_range, out_valid_r,
    ($signed(out_data_r[57:48]) <= 10'sd500) && ($signed(out_data_r[57:48]) >= -10'sd500),
    "rotation out of range")
endmodule

### tb/sv/testbench.sv
// Self-checking testbench for visual_servo_aim_and_approach: random and directed ball offsets,
// register settings and back-pressure, with results checked against a tick predictor.
// Depends on vsaa_pkg and the block's top level.
`timescale 1ns / 1ps

class servo_scoreboard;
  longint aim_g, appr_g, x_db, grab_line, y_db, scale;
  bit mode;
  longint tgt, vx, vy, wz;
  logic [63:0] expected_q[$];
  int mismatches;

  function new();
    aim_g = -6; appr_g = -6; x_db = 5; grab_line = -80; y_db = 10; scale = 256;
    mode = 0; tgt = 0; vx = 0; vy = 0; wz = 0; mismatches = 0;
  endfunction

  function void write_reg(vsaa_pkg::cfg_reg_t r, logic [11:0] v);
    case (r)
      vsaa_pkg::CFG_AIM_GAIN:      aim_g = longint'($signed(v[7:0]));
      vsaa_pkg::CFG_APPROACH_GAIN: appr_g = longint'($signed(v[7:0]));
      vsaa_pkg::CFG_X_DEADBAND:    x_db = longint'(v[8:0]);
      vsaa_pkg::CFG_GRAB_Y:        grab_line = longint'($signed(v[8:0]));
      vsaa_pkg::CFG_Y_DEADBAND:    y_db = longint'(v[7:0]);
      vsaa_pkg::CFG_CHASSIS_SCALE: scale = longint'(v[11:0]);
      default: ;
    endcase
  endfunction

  function longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function longint round_div(longint num, longint den);
    longint m;
    m = num < 0 ? -num : num;
    m = (m + den / 2) / den;
    return num < 0 ? -m : m;
  endfunction

  function longint quarter_wave(longint u);
    longint sq, acc, r;
    sq = (u * u) >>> 16;
    acc = 43069;
    acc = -1256749 + ((acc * sq) >>> 16);
    acc = 21392326 + ((acc * sq) >>> 16);
    acc = -173399667 + ((acc * sq) >>> 16);
    acc = 421657428 + ((acc * sq) >>> 16);
    r = (acc * u) >>> 16;
    if (r <= 0) return 0;
    r = (r + 8192) >>> 14;
    return r > 16384 ? 16384 : r;
  endfunction

  function longint sine_at(int unsigned a);
    int unsigned quad;
    longint u, v;
    quad = (a >> 6) & 3;
    u = longint'(a & 63) << 10;
    if (quad[0]) u = 65536 - u;
    v = quarter_wave(u);
    return quad[1] ? -v : v;
  endfunction

  function void note_tick(logic [9:0] xb, logic [8:0] yb);
    longint x, y, dy, sg, t, mag, q;
    int unsigned phase, a;
    bit grab;
    x = longint'($signed(xb));
    y = longint'($signed(yb));
    grab = 0;
    tgt = clamp(tgt, -70000, 70000);
    if (!mode) begin
      if (x > x_db || x < -x_db || tgt >= 40000 || tgt <= -40000) begin
        tgt = clamp(tgt + aim_g * x, -131072, 131071);
        wz = clamp(round_div(-tgt * 500, 70000), -500, 500);
      end else begin
        mode = 1;
      end
    end else begin
      tgt = clamp(tgt + appr_g * x, -131072, 131071);
      if (y > grab_line + y_db || y < grab_line - y_db) begin
        mag = tgt < 0 ? -tgt : tgt;
        q = (mag * 20480000 + 764047 / 2) / 764047;
        phase = int'((tgt > 0 ? (64'sd16777216 - q) : q) & 64'hFFFFFF);
        a = ((phase + (1 << 15)) >> 16) & 255;
        dy = y - grab_line;
        sg = dy > 0 ? 1 : (dy < 0 ? -1 : 0);
        t = dy * 500 * scale + sg * 60 * 240 * 256;
        vx = clamp(round_div(sine_at(a) * t, 64'd1006632960), -16384, 16383);
        vy = clamp(round_div(sine_at((a + 64) & 255) * t, 64'd1006632960), -16384, 16383);
        wz = 0;
      end else begin
        grab = 1;
        mode = 0;
      end
    end
    expected_q.push_back({4'b0, mode, grab, wz[9:0], vy[14:0], vx[14:0], tgt[17:0]});
  endfunction

  function void check_result(logic [63:0] got);
    logic [63:0] want;
    bit bad;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat %h", got);
      return;
    end
    want = expected_q.pop_front();
    bad = (got[17:0] !== want[17:0]) || (got[32:18] !== want[32:18]) ||
          (got[47:33] !== want[47:33]) || (got[57:48] !== want[57:48]) ||
          (got[58] !== want[58]) || (got[59] !== want[59]);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: tgt %0d/%0d vx %0d/%0d vy %0d/%0d wz %0d/%0d grab %b/%b mode %b/%b",
                 $signed(want[17:0]), $signed(got[17:0]), $signed(want[32:18]),
                 $signed(got[32:18]), $signed(want[47:33]), $signed(got[47:33]),
                 $signed(want[57:48]), $signed(got[57:48]), want[58], got[58],
                 want[59], got[59]);
    end
  endfunction
endclass

module testbench;
  localparam int CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // ball_x[9:0], ball_y[18:10]
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // gimbal_target[17:0], chassis_vx[32:18], chassis_vy[47:33],
                           // chassis_wz[57:48], grab_pulse[58], mode_now[59]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [11:0] cfg_data;

  int snd_idle;
  int rcv_idle;
  int cycles;
  servo_scoreboard sb;

  visual_servo_aim_and_approach DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("** visual_servo_aim_and_approach: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    out_tready = 0;
    forever begin
      @(negedge clk);
      out_tready = rst_n && ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  task automatic write_reg(vsaa_pkg::cfg_reg_t r, logic [11:0] v);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = r;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(r, v);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic write_all(logic [11:0] ag, logic [11:0] pg, logic [11:0] xd,
                           logic [11:0] gy, logic [11:0] yd, logic [11:0] sc);
    write_reg(vsaa_pkg::CFG_AIM_GAIN, ag);
    write_reg(vsaa_pkg::CFG_APPROACH_GAIN, pg);
    write_reg(vsaa_pkg::CFG_X_DEADBAND, xd);
    write_reg(vsaa_pkg::CFG_GRAB_Y, gy);
    write_reg(vsaa_pkg::CFG_Y_DEADBAND, yd);
    write_reg(vsaa_pkg::CFG_CHASSIS_SCALE, sc);
  endtask

  // in_tvalid stays high between back-to-back beats
  task automatic send_tick(logic [9:0] x, logic [8:0] y);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid = 0;
      @(negedge clk);
    end
    in_tvalid = 1;
    in_tdata = {5'b0, y, x};
    do @(posedge clk); while (!in_tready);
    sb.note_tick(x, y);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic random_ticks(int n);
    logic [9:0] x;
    logic [8:0] y;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 7) begin
        x = 10'($signed($urandom_range(16)) - 8);
        y = 9'(sb.grab_line + $signed($urandom_range(80)) - 40);
      end else begin
        x = 10'($urandom);
        y = 9'($urandom);
      end
      if (i == n / 2) drain();
      send_tick(x, y);
    end
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    snd_idle = 0;
    rcv_idle = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    send_tick(10'd320, 9'd0);
    send_tick(-10'sd320, 9'd240);
    send_tick(10'h1FF, 9'h0FF);
    send_tick(10'h200, 9'h100);
    send_tick(10'd0, 9'd0);
    send_tick(10'd3, 9'd100);
    send_tick(10'd0, -9'sd80);
    send_tick(10'd0, -9'sd240);
    send_tick(10'd0, -9'sd90);
    send_tick(10'd0, -9'sd70);
    send_tick(10'd2, 9'd0);
    send_tick(10'd0, -9'sd256);
    send_tick(10'd5, -9'sd80);
    send_tick(10'd6, 9'd0);
    for (int i = 0; i < 10; i++) send_tick(-10'sd512, 9'd0);
    drain();

    write_all(-12'sd64, 12'd64, 12'd320, 12'd240, 12'd240, 12'd4095);
    snd_idle = 28; rcv_idle = 87;
    random_ticks(150);
    drain();

    write_all(12'd64, -12'sd64, 12'd0, -12'sd240, 12'd0, 12'd0);
    snd_idle = 87; rcv_idle = 28;
    random_ticks(150);
    drain();

    write_all(12'hFFA, 12'hFFA, 12'hFFF, 12'hFB0, 12'hFFF, 12'hFFF);
    snd_idle = 0; rcv_idle = 0;
    random_ticks(75);
    drain();
    write_all(12'h0FF, 12'h080, 12'd8, 12'd0, 12'd20, 12'd256);
    random_ticks(75);
    drain();

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("** visual_servo_aim_and_approach: PASSED **");
    end else begin
      $display("** visual_servo_aim_and_approach: FAILED **");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+design
design/vsaa_pkg.sv
design/vsaa_serial_unit.sv
design/vsaa_trig_rom.sv
design/visual_servo_aim_and_approach.sv
tb/sv/testbench.sv
